[rtl/core/hds_pkg.sv]
// Shared constants and helper functions for the hyperelastic deviatoric stress core.
// Depends on nothing; used by hyperelastic_deviatoric_stress_top.
`default_nettype none
package hds_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int LOG_FRAC  = 24;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   // configuration register indexes
   localparam logic [3:0] CSR_SHEAR = 4'd0;
   localparam logic [3:0] CSR_STIFF = 4'd1;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SAT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_J = 2'd2;

   // bit-by-bit integer square root, elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bitv;
      v    = x;
      r    = '0;
      bitv = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Q30 value of 2^(2^-i)
   function automatic logic [63:0] root_c(input int i);
      logic [63:0] c;
      c = isqrt64(64'h1 << 61);
      for (int k = 2; k <= i; k++) begin
         c = isqrt64(c << 30);
      end
      return c;
   endfunction

   // floor(x/3) by reciprocal multiply, exact for all 32-bit x
   function automatic logic [31:0] div3(input logic [31:0] x);
      logic [63:0] pr;
      pr = 64'(x) * 64'h0_AAAA_AAAB;
      return {1'b0, pr[63:33]};
   endfunction

endpackage
`default_nettype wire

[rtl/core/hyperelastic_deviatoric_stress_top.sv]
// Top level of the hyperelastic deviatoric stress core: a fully pipelined evaluator.
// Depends on hds_pkg (constants, root table and divide-by-three helpers).
`default_nettype none
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req_    | in        | req_tvalid/tready    | tdata: six B components, J
//  rsp_    | out       | rsp_tvalid/tready    | tdata: six stress components; tuser: status
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data (register write)
//
//  One item enters per cycle while a stalled result does not hold the pipeline.
//  The depth comes from three chains of 24 multiply stages (log2 squaring and two
//  pow2 root-product chains) plus 19 stages for the rest of the datapath.
//  Reset clears the pipeline valid bits but not the item data; the coefficient registers return to 1.0.
//  A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
//
module hyperelastic_deviatoric_stress_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata, low bit up: b_xx, b_yy, b_zz, b_xy, b_yz, b_xz (32 each), vol_ratio (31), pad
   input  wire logic [223:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: s_xx, s_yy, s_zz, s_xy, s_yz, s_xz (32 each)
   output logic [191:0]      rsp_tdata,
   // tuser: status (2)
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int LF = hds_pkg::LOG_FRAC;

   // stage map
   localparam int ST_IN   = 0;
   localparam int ST_NORM = 1;
   localparam int ST_LOG  = 2;             // LF squaring stages
   localparam int ST_LJ   = ST_LOG + LF;
   localparam int ST_DIV  = ST_LJ + 1;
   localparam int ST_PA0  = ST_DIV + 1;
   localparam int ST_PA   = ST_PA0 + 1;     // LF root stages for J^(-2/3)
   localparam int ST_PM   = ST_PA + LF;
   localparam int ST_P    = ST_PM + 1;
   localparam int ST_X    = ST_P + 1;
   localparam int ST_WM   = ST_X + 1;
   localparam int ST_W    = ST_WM + 1;
   localparam int ST_YM   = ST_W + 1;
   localparam int ST_Y    = ST_YM + 1;
   localparam int ST_PB0  = ST_Y + 1;
   localparam int ST_PB   = ST_PB0 + 1;     // LF root stages for the scale factor
   localparam int ST_K0   = ST_PB + LF;
   localparam int ST_K1   = ST_K0 + 1;
   localparam int ST_K2   = ST_K1 + 1;
   localparam int ST_DM   = ST_K2 + 1;
   localparam int ST_SH   = ST_DM + 1;
   localparam int ST_OUT  = ST_SH + 1;
   localparam int NST     = ST_OUT + 1;

   typedef struct packed {
      logic [5:0][31:0]  b;
      logic [30:0]       j;
      logic              inv;
      logic signed [33:0] i1;
      logic [5:0][35:0]  d;
      logic [4:0]        p;
      logic [30:0]       m;
      logic [23:0]       frac;
      logic signed [31:0] lj;
      logic signed [31:0] e23;
      logic signed [31:0] e53;
      logic [31:0]       r;
      logic signed [15:0] n;
      logic [23:0]       f;
      logic [30:0]       rg;
      logic signed [15:0] ng;
      logic [64:0]       pm;
      logic signed [47:0] ps;
      logic              xneg;
      logic [42:0]       xm;
      logic [52:0]       ph;
      logic [51:0]       pl;
      logic [33:0]       wm;
      logic [64:0]       ym;
      logic signed [39:0] z;
      logic [30:0]       rs;
      logic signed [15:0] ns;
      logic [30:0]       qa;
      logic [30:0]       qr;
      logic [1:0]        ra;
      logic [1:0]        rr;
      logic [61:0]       t;
      logic [32:0]       s1;
      logic              tab;
      logic [61:0]       k3;
      logic [5:0][66:0]  dl;
      logic [5:0][66:0]  dh;
      logic [5:0]        vhi;
      logic [5:0][31:0]  vlo;
      logic [5:0][31:0]  s;
      logic [1:0]        status;
   } item_type;

   item_type        st_ff [NST];
   item_type        st_in [NST];
   logic [NST-1:0]  vld_ff;
   logic            en;

   logic [30:0]     shear_ff;
   logic [30:0]     stiff_ff;

   // whole pipeline advances unless the result register holds an untaken item
   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = st_ff[NST-1].s;
   assign rsp_tuser  = st_ff[NST-1].status;
   assign csr_ready  = 1'b1;

   // coefficient registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         shear_ff <= 31'(1 << hds_pkg::FRAC_BITS);
         stiff_ff <= 31'(1 << hds_pkg::FRAC_BITS);
      end else if (csr_valid) begin
         if (csr_index == hds_pkg::CSR_SHEAR) begin
            shear_ff <= csr_data[30:0];
         end else if (csr_index == hds_pkg::CSR_STIFF) begin
            stiff_ff <= csr_data[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_st
      if (k == ST_IN) begin : g_in
         // capture item, form the trace
         always_comb begin
            st_in[k]     = '0;
            for (int i = 0; i < 6; i++) begin
               st_in[k].b[i] = req_tdata[32*i +: 32];
            end
            st_in[k].j   = req_tdata[222:192];
            st_in[k].inv = (req_tdata[222:192] == '0);
            st_in[k].i1  = 34'($signed(req_tdata[31:0])) + 34'($signed(req_tdata[63:32]))
                         + 34'($signed(req_tdata[95:64]));
         end
      end else if (k == ST_NORM) begin : g_norm
         // deviator numerators, normalize J to [1,2) in Q30
         always_comb begin
            logic signed [35:0] bx;
            logic [4:0]         pp;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               bx = 36'($signed(st_ff[k-1].b[i]));
               if (i < 3) begin
                  st_in[k].d[i] = bx + (bx <<< 1) - 36'(st_ff[k-1].i1);
               end else begin
                  st_in[k].d[i] = bx + (bx <<< 1);
               end
            end
            pp = '0;
            for (int q = 0; q < 31; q++) begin
               if (st_ff[k-1].j[q]) begin
                  pp = 5'(q);
               end
            end
            st_in[k].p    = pp;
            st_in[k].m    = 31'(st_ff[k-1].j << (5'd30 - pp));
            st_in[k].frac = '0;
         end
      end else if (k >= ST_LOG && k < ST_LOG + LF) begin : g_log
         // one log2 fraction bit per stage
         always_comb begin
            logic [61:0] sq;
            st_in[k]      = st_ff[k-1];
            sq            = 62'(st_ff[k-1].m) * 62'(st_ff[k-1].m);
            st_in[k].frac = {st_ff[k-1].frac[22:0], sq[61]};
            st_in[k].m    = sq[61] ? sq[61:31] : sq[60:30];
         end
      end else if (k == ST_LJ) begin : g_lj
         always_comb begin
            logic signed [5:0] ip;
            st_in[k]    = st_ff[k-1];
            ip          = $signed({1'b0, st_ff[k-1].p}) - 6'sd16;
            st_in[k].lj = {{2{ip[5]}}, ip, st_ff[k-1].frac};
         end
      end else if (k == ST_DIV) begin : g_div
         // exponents -2L/3 and -5L/3, rounded
         always_comb begin
            logic signed [33:0] l34;
            logic signed [33:0] t2;
            logic signed [33:0] t5;
            logic [31:0]        q2;
            logic [31:0]        q5;
            st_in[k] = st_ff[k-1];
            l34      = 34'(st_ff[k-1].lj);
            t2       = -(l34 <<< 1);
            t5       = -((l34 <<< 2) + l34);
            q2       = hds_pkg::div3(32'(t2[33] ? -t2 : t2) + 32'd1);
            q5       = hds_pkg::div3(32'(t5[33] ? -t5 : t5) + 32'd1);
            st_in[k].e23 = t2[33] ? -$signed(q2) : $signed(q2);
            st_in[k].e53 = t5[33] ? -$signed(q5) : $signed(q5);
         end
      end else if (k == ST_PA0) begin : g_pa0
         // split the exponent into a signed integer part and a fraction
         always_comb begin
            st_in[k]   = st_ff[k-1];
            st_in[k].n = 16'($signed(st_ff[k-1].e23[31:24]));
            st_in[k].f = st_ff[k-1].e23[23:0];
            st_in[k].r = 32'h4000_0000;
         end
      end else if ((k >= ST_PA && k < ST_PA + LF) || (k >= ST_PB && k < ST_PB + LF)) begin : g_pw
         localparam int          IDX = (k >= ST_PB) ? k - ST_PB + 1 : k - ST_PA + 1;
         localparam logic [63:0] C   = hds_pkg::root_c(IDX);
         // multiply in the root of one fraction bit
         always_comb begin
            logic [63:0] pr;
            st_in[k] = st_ff[k-1];
            pr       = (64'(st_ff[k-1].r) * C + 64'h2000_0000) >> 30;
            if (st_ff[k-1].f[LF - IDX]) begin
               st_in[k].r = pr[31:0];
            end
         end
      end else if (k == ST_PM) begin : g_pm
         always_comb begin
            logic [30:0] rc;
            logic [33:0] im;
            st_in[k]    = st_ff[k-1];
            rc          = st_ff[k-1].r[31] ? 31'h7FFF_FFFF : st_ff[k-1].r[30:0];
            im          = st_ff[k-1].i1[33] ? 34'(-st_ff[k-1].i1) : 34'(st_ff[k-1].i1);
            st_in[k].rg = rc;
            st_in[k].ng = st_ff[k-1].n;
            st_in[k].pm = 65'(im) * 65'(rc);
         end
      end else if (k == ST_P) begin : g_p
         // P = J^(-2/3) * I1 back in Q16
         always_comb begin
            logic [5:0]  sh;
            logic [65:0] rnd;
            logic [47:0] pa;
            st_in[k]    = st_ff[k-1];
            sh          = 6'(16'sd30 - st_ff[k-1].ng);
            rnd         = (66'(st_ff[k-1].pm) + (66'd1 << (sh - 6'd1))) >> sh;
            pa          = rnd[47:0];
            st_in[k].ps = st_ff[k-1].i1[33] ? -$signed(pa) : $signed(pa);
         end
      end else if (k == ST_X) begin : g_x
         always_comb begin
            logic signed [48:0] x;
            logic [47:0]        xa;
            st_in[k]      = st_ff[k-1];
            x             = 49'(st_ff[k-1].ps) - 49'(3 << hds_pkg::FRAC_BITS);
            xa            = 48'(x[48] ? -x : x);
            st_in[k].xneg = x[48];
            // anything at or above 2^42 caps w anyway
            st_in[k].xm   = (xa >= 48'h400_0000_0000) ? 43'h400_0000_0000 : xa[42:0];
         end
      end else if (k == ST_WM) begin : g_wm
         always_comb begin
            st_in[k]    = st_ff[k-1];
            st_in[k].ph = 53'(st_ff[k-1].xm[42:21]) * 53'(stiff_ff);
            st_in[k].pl = 52'(st_ff[k-1].xm[20:0]) * 52'(stiff_ff);
         end
      end else if (k == ST_W) begin : g_w
         always_comb begin
            logic [74:0] wp;
            logic [65:0] wr;
            st_in[k]    = st_ff[k-1];
            wp          = (75'(st_ff[k-1].ph) << 21) + 75'(st_ff[k-1].pl);
            wr          = 66'((wp + 75'd256) >> 9);
            st_in[k].wm = (wr > 66'h2_0000_0000) ? 34'h2_0000_0000 : wr[33:0];
         end
      end else if (k == ST_YM) begin : g_ym
         always_comb begin
            st_in[k]    = st_ff[k-1];
            st_in[k].ym = 65'(st_ff[k-1].wm) * 65'(hds_pkg::LOG2E_Q30);
         end
      end else if (k == ST_Y) begin : g_y
         // y = w*log2(e), then add the J^(-5/3) exponent
         always_comb begin
            logic [64:0]        ya;
            logic signed [39:0] y;
            st_in[k]   = st_ff[k-1];
            ya         = (st_ff[k-1].ym + 65'h2000_0000) >> 30;
            y          = st_ff[k-1].xneg ? -$signed(40'(ya)) : $signed(40'(ya));
            st_in[k].z = y + 40'(st_ff[k-1].e53);
         end
      end else if (k == ST_PB0) begin : g_pb0
         always_comb begin
            st_in[k]   = st_ff[k-1];
            st_in[k].n = st_ff[k-1].z[39:24];
            st_in[k].f = st_ff[k-1].z[23:0];
            st_in[k].r = 32'h4000_0000;
         end
      end else if (k == ST_K0) begin : g_k0
         // split a and the mantissa into thirds and remainders
         always_comb begin
            logic [30:0] rc;
            logic [31:0] qa;
            logic [31:0] qr;
            st_in[k]    = st_ff[k-1];
            rc          = st_ff[k-1].r[31] ? 31'h7FFF_FFFF : st_ff[k-1].r[30:0];
            qa          = hds_pkg::div3(32'(shear_ff));
            qr          = hds_pkg::div3(32'(rc));
            st_in[k].rs = rc;
            st_in[k].ns = st_ff[k-1].n;
            st_in[k].qa = qa[30:0];
            st_in[k].qr = qr[30:0];
            st_in[k].ra = 2'(32'(shear_ff) - 3 * qa);
            st_in[k].rr = 2'(32'(rc) - 3 * qr);
         end
      end else if (k == ST_K1) begin : g_k1
         always_comb begin
            st_in[k]     = st_ff[k-1];
            st_in[k].t   = 62'(st_ff[k-1].qa) * 62'(st_ff[k-1].qr);
            st_in[k].s1  = 33'(st_ff[k-1].qa) * 33'(st_ff[k-1].rr)
                         + 33'(st_ff[k-1].qr) * 33'(st_ff[k-1].ra);
            // (ra*rr + 1)/3 is one exactly when ra*rr is at least two
            st_in[k].tab = (st_ff[k-1].ra != 2'd0) && (st_ff[k-1].rr != 2'd0)
                         && !((st_ff[k-1].ra == 2'd1) && (st_ff[k-1].rr == 2'd1));
         end
      end else if (k == ST_K2) begin : g_k2
         always_comb begin
            st_in[k]    = st_ff[k-1];
            st_in[k].k3 = (st_ff[k-1].t << 1) + st_ff[k-1].t + 62'(st_ff[k-1].s1)
                        + 62'(st_ff[k-1].tab);
         end
      end else if (k == ST_DM) begin : g_dm
         // per component, scale by k3 in two partial products
         always_comb begin
            logic [35:0] da;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               da = st_ff[k-1].d[i][35] ? -st_ff[k-1].d[i] : st_ff[k-1].d[i];
               st_in[k].dl[i] = 67'(da) * 67'(st_ff[k-1].k3[30:0]);
               st_in[k].dh[i] = 67'(da) * 67'(st_ff[k-1].k3[61:31]);
            end
         end
      end else if (k == ST_SH) begin : g_sh
         // apply 2^(ns-30) / 2^FRAC with rounding
         always_comb begin
            logic signed [16:0] ks;
            logic [6:0]         kk;
            logic [5:0]         ls;
            logic [97:0]        prod;
            logic [129:0]       v;
            st_in[k] = st_ff[k-1];
            ks = 17'sd46 - 17'(st_ff[k-1].ns);
            kk = (ks > 17'sd100) ? 7'd100 : 7'(ks);
            ls = (-ks > 17'sd32) ? 6'd32 : 6'(-ks);
            for (int i = 0; i < 6; i++) begin
               prod = (98'(st_ff[k-1].dh[i]) << 31) + 98'(st_ff[k-1].dl[i]);
               if (ks > 17'sd0) begin
                  v = 130'((101'(prod) + (101'd1 << (kk - 7'd1))) >> kk);
               end else begin
                  v = 130'(prod) << ls;
               end
               st_in[k].vhi[i] = |v[129:32];
               st_in[k].vlo[i] = v[31:0];
            end
         end
      end else begin : g_out
         // saturate, restore sign, build status
         always_comb begin
            logic        neg;
            logic        sat;
            logic        any;
            logic [31:0] mg;
            st_in[k] = st_ff[k-1];
            any      = 1'b0;
            for (int i = 0; i < 6; i++) begin
               neg = st_ff[k-1].d[i][35];
               sat = st_ff[k-1].vhi[i]
                  || (neg ? (st_ff[k-1].vlo[i] > 32'h8000_0000)
                          : (st_ff[k-1].vlo[i] > 32'h7FFF_FFFF));
               mg  = sat ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : st_ff[k-1].vlo[i];
               any = any | sat;
               st_in[k].s[i] = st_ff[k-1].inv ? 32'd0 : (neg ? -mg : mg);
            end
            if (st_ff[k-1].inv) begin
               st_in[k].status = hds_pkg::STATUS_BAD_J;
            end else if (any) begin
               st_in[k].status = hds_pkg::STATUS_SAT;
            end else begin
               st_in[k].status = hds_pkg::STATUS_OK;
            end
         end
      end
   end

endmodule
`default_nettype wire
